[rtl/core/adsr_envelope_generator_assert.svh]
// Assertion macros for the envelope generator RTL.
`ifndef ADSR_ENVELOPE_GENERATOR_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_ASSERT_SVH

// Condition that holds at every clock edge out of reset.
`define ADSR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition in one cycle implies another in the next cycle.
`define ADSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/adsr_pkg.sv]
package adsr_pkg;

  // Default level fraction width (Q1.24 level)
  localparam int FRAC_BITS_DEF = 24;

  // Fixed field widths
  localparam int CFG_W     = 25;
  localparam int SNAP_W    = 16;
  localparam int ENV_W     = 17;
  localparam int CFG_IDX_W = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_RATE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_RATE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SNAP_THRESHOLD = 3'd4;

  // Register reset values
  localparam logic [CFG_W-1:0]  RATE_RST    = 25'd16777216;
  localparam logic [CFG_W-1:0]  SUSTAIN_RST = 25'd16777216;
  localparam logic [SNAP_W-1:0] SNAP_RST    = 16'd168;

  // Envelope stages
  typedef enum logic [1:0] {
    STAGE_ATTACK  = 2'd0,
    STAGE_DECAY   = 2'd1,
    STAGE_SUSTAIN = 2'd2,
    STAGE_RELEASE = 2'd3
  } stage_t;

endpackage

[rtl/core/adsr_approach.sv]
// One exponential step: move cur toward tgt by (distance * rate) >> FRAC_BITS,
// at least one LSB when distance and rate are nonzero, never past the target.
module adsr_approach #(
  parameter int FRAC_BITS = adsr_pkg::FRAC_BITS_DEF
) (
  input  logic [FRAC_BITS:0] cur,
  input  logic [FRAC_BITS:0] tgt,
  input  logic [FRAC_BITS:0] rate,
  output logic [FRAC_BITS:0] nxt
);

  localparam int LW = FRAC_BITS + 1;

  logic            up;
  logic [LW-1:0]   mag;
  logic [2*LW-1:0] prod;
  logic [LW-1:0]   mv_raw;
  logic [LW-1:0]   mv_min;
  logic [LW-1:0]   mv;

  // Distance and direction
  assign up  = (tgt >= cur);
  assign mag = up ? (tgt - cur) : (cur - tgt);

  // Scaled move, truncated
  assign prod   = mag * rate;
  assign mv_raw = prod[FRAC_BITS +: LW];

  // Minimum one LSB move, capped at the distance
  assign mv_min = (mv_raw == '0 && mag != '0 && rate != '0) ? LW'(1) : mv_raw;
  assign mv     = (mv_min > mag) ? mag : mv_min;

  assign nxt = up ? (cur + mv) : (cur - mv);

endmodule

[rtl/core/adsr_envelope_generator.sv]
// ADSR envelope generator, exponential segments.
// Input channel: one gate bit per audio sample (in_valid / in_stall). A rising
// gate starts attack, a falling gate starts release.
// Result channel: one envelope level (Q1.16, 65536 = full scale) and the stage
// (0 attack, 1 decay, 2 sustain, 3 release) per accepted sample
// (out_valid / out_stall).
// Config channel: cfg_valid / cfg_ready, cfg_index selects attack, decay and
// release rate, sustain level or snap threshold; unknown indexes are dropped.
// cfg_ready is always high; write only while no sample is in flight.
// Results are registered. Throughput: one sample per cycle while in_stall is
// low. The level update (one multiply, one add and compare) completes in the
// accept cycle, so the next sample may follow at once.
// Stall: a two-entry output (result register plus skid register) lets one more
// sample in while a result waits; in_stall rises only when both are full.
// Reset: level 0, stage release, last gate low, registers at their defaults,
// output empty.
module adsr_envelope_generator #(
  parameter int FRAC_BITS = adsr_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // sample input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_gate_level,
  // result output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [adsr_pkg::ENV_W-1:0]     out_envelope,
  output logic [1:0]                     out_stage,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [adsr_pkg::CFG_W-1:0]     cfg_data
);

  `include "adsr_envelope_generator_assert.svh"

  localparam int LW      = FRAC_BITS + 1;
  localparam int ENV_SHR = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int ENV_SHL = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam longint ONE_L = 64'd1 << FRAC_BITS;
  localparam logic [31:0]   ONE32    = 32'(ONE_L);
  localparam logic [LW-1:0] ONE_LV   = LW'(ONE_L);
  localparam logic [LW-1:0] SUS_RATE = LW'((ONE_L + 500) / 1000);

  // Config value limited to full scale
  function automatic logic [LW-1:0] clamp_one(input logic [adsr_pkg::CFG_W-1:0] v);
    return (32'(v) > ONE32) ? ONE_LV : LW'(v);
  endfunction

  // Configuration registers
  logic [adsr_pkg::CFG_W-1:0]  attack_rate_r;
  logic [adsr_pkg::CFG_W-1:0]  decay_rate_r;
  logic [adsr_pkg::CFG_W-1:0]  release_rate_r;
  logic [adsr_pkg::CFG_W-1:0]  sustain_level_r;
  logic [adsr_pkg::SNAP_W-1:0] snap_threshold_r;

  // Envelope state
  logic [LW-1:0]    level_r, level_nxt;
  adsr_pkg::stage_t stage_r, stage_nxt;
  logic             last_gate_r;

  // Output register and skid register
  logic                       out_valid_r;
  logic [adsr_pkg::ENV_W-1:0] out_env_r;
  adsr_pkg::stage_t           out_stage_r;
  logic                       skid_valid_r;
  logic [adsr_pkg::ENV_W-1:0] skid_env_r;
  adsr_pkg::stage_t           skid_stage_r;

  logic                       in_acc;
  logic                       out_take;
  logic                       cfg_acc;
  logic                       gate_edge;
  adsr_pkg::stage_t           eff_stage;
  logic [LW-1:0]              sus;
  logic [LW-1:0]              app_tgt;
  logic [LW-1:0]              app_rate;
  logic [LW-1:0]              app_lvl;
  logic [LW-1:0]              sus_gap;
  logic [adsr_pkg::ENV_W-1:0] env_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid & ~skid_valid_r;
  assign out_take  = out_valid_r & ~out_stall;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_rate_r    <= adsr_pkg::RATE_RST;
      decay_rate_r     <= adsr_pkg::RATE_RST;
      release_rate_r   <= adsr_pkg::RATE_RST;
      sustain_level_r  <= adsr_pkg::SUSTAIN_RST;
      snap_threshold_r <= adsr_pkg::SNAP_RST;
    end else if (cfg_acc) begin
      case (cfg_index)
        adsr_pkg::REG_ATTACK_RATE:    attack_rate_r    <= cfg_data;
        adsr_pkg::REG_DECAY_RATE:     decay_rate_r     <= cfg_data;
        adsr_pkg::REG_RELEASE_RATE:   release_rate_r   <= cfg_data;
        adsr_pkg::REG_SUSTAIN_LEVEL:  sustain_level_r  <= cfg_data;
        adsr_pkg::REG_SNAP_THRESHOLD: snap_threshold_r <= cfg_data[adsr_pkg::SNAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage after gate edge, and step target and rate for it
  always_comb begin
    sus       = clamp_one(sustain_level_r);
    gate_edge = (in_gate_level != last_gate_r);
    if (gate_edge) begin
      eff_stage = in_gate_level ? adsr_pkg::STAGE_ATTACK : adsr_pkg::STAGE_RELEASE;
    end else begin
      eff_stage = stage_r;
    end
    case (eff_stage)
      adsr_pkg::STAGE_ATTACK: begin
        app_tgt  = ONE_LV;
        app_rate = clamp_one(attack_rate_r);
      end
      adsr_pkg::STAGE_DECAY: begin
        app_tgt  = sus;
        app_rate = clamp_one(decay_rate_r);
      end
      adsr_pkg::STAGE_SUSTAIN: begin
        app_tgt  = sus;
        app_rate = SUS_RATE;
      end
      default: begin
        app_tgt  = '0;
        app_rate = clamp_one(release_rate_r);
      end
    endcase
  end

  adsr_approach #(
    .FRAC_BITS (FRAC_BITS)
  ) u_approach (
    .cur  (level_r),
    .tgt  (app_tgt),
    .rate (app_rate),
    .nxt  (app_lvl)
  );

  // Snap checks and next state
  always_comb begin
    level_nxt = app_lvl;
    stage_nxt = eff_stage;
    sus_gap   = (app_lvl >= sus) ? (app_lvl - sus) : (sus - app_lvl);
    case (eff_stage)
      adsr_pkg::STAGE_ATTACK: begin
        if ((32'(app_lvl) + 32'(snap_threshold_r)) >= ONE32) begin
          level_nxt = ONE_LV;
          stage_nxt = adsr_pkg::STAGE_DECAY;
        end
      end
      adsr_pkg::STAGE_DECAY: begin
        if (32'(sus_gap) <= 32'(snap_threshold_r)) begin
          level_nxt = sus;
          stage_nxt = adsr_pkg::STAGE_SUSTAIN;
        end
      end
      default: ;
    endcase
    env_nxt = adsr_pkg::ENV_W'((32'(level_nxt) >> ENV_SHR) << ENV_SHL);
  end

  // State update on each accepted sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      stage_r     <= adsr_pkg::STAGE_RELEASE;
      last_gate_r <= 1'b0;
    end else if (in_acc) begin
      level_r     <= level_nxt;
      stage_r     <= stage_nxt;
      last_gate_r <= in_gate_level;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_env_r   <= skid_env_r;
        out_stage_r <= skid_stage_r;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_take) begin
        out_env_r   <= env_nxt;
        out_stage_r <= stage_nxt;
      end else begin
        skid_env_r   <= env_nxt;
        skid_stage_r <= stage_nxt;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_envelope = out_env_r;
  assign out_stage    = out_stage_r;

  // Checks
  `ADSR_ASSERT_ALWAYS(a_level_range, level_r <= ONE_LV, "level above full scale")
  `ADSR_ASSERT_ALWAYS(a_skid_order, !skid_valid_r || out_valid_r,
    "skid full with output empty")
  `ADSR_ASSERT_NEXT(a_gate_rise, in_acc && in_gate_level && !last_gate_r,
    stage_r == adsr_pkg::STAGE_ATTACK || stage_r == adsr_pkg::STAGE_DECAY,
    "rising gate did not start attack")
  `ADSR_ASSERT_NEXT(a_gate_fall, in_acc && !in_gate_level && last_gate_r,
    stage_r == adsr_pkg::STAGE_RELEASE, "falling gate did not start release")
  `ADSR_ASSERT_NEXT(a_idle_hold, !in_acc, $stable(level_r) && $stable(stage_r),
    "state moved without a sample")

endmodule
